// ===== rtl/lst_pkg.sv =====
// lst_pkg: shared types and constants of the led scan time base
// used by every module in rtl; no dependencies

package lst_pkg;

	// default parameter values
	localparam int unsigned SUB_TICKS_DEF    = 8;
	localparam int unsigned DIGITS_DEF       = 7;
	localparam int unsigned SECOND_STEPS_DEF = 1000;
	localparam int unsigned REFRESH_AT_DEF   = 103;

	// fixed 8 ms system tick, in 1 ms steps
	localparam int unsigned SYS_TICK_STEPS = 8;
	localparam int unsigned SYS_TICK_W     = 3;

	// field widths
	localparam int unsigned SEG_W  = 8;
	localparam int unsigned COM_W  = 7;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	// request kinds carried in tuser
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// timing pulses for one item
	typedef struct packed {
		logic ms_step;
		logic sys_tick;
		logic second_mark;
		logic refresh_request;
	} pulse_t;

endpackage

// ===== rtl/led_scan_timebase.sv =====
// led_scan_timebase: top level with input register, time base, scanner and
// result register; depends on lst_pkg, lst_timebase and lst_scan

// Each item is a 125 us tick (tuser 0) or a display buffer write (tuser 1), and
// each gives exactly one result. The block takes one item per clock while the
// result side accepts: an item waits in the input register, its counter and scan
// update runs as it leaves that register, and its result lands in the output
// register and is held there until the result side accepts.
// Every SUB_TICKS ticks make a 1 ms step, which may raise sys_tick (8 ms),
// second_mark (SECOND_STEPS ms) and refresh_request, and moves the scan to the
// next slot unless power_down; a write shows when its digit is next scanned.

module led_scan_timebase #(
	parameter int unsigned SUB_TICKS    = lst_pkg::SUB_TICKS_DEF,
	parameter int unsigned DIGITS       = lst_pkg::DIGITS_DEF,
	parameter int unsigned SECOND_STEPS = lst_pkg::SECOND_STEPS_DEF,
	parameter int unsigned REFRESH_AT   = lst_pkg::REFRESH_AT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// power_down [0], digit_index [3:1], digit_data [11:4], zero [15:12]
	input  logic [lst_pkg::IN_TDATA_W-1:0]  s_tdata,
	// req_type [0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// seg_out [7:0], com_out [14:8], ms_step [15], sys_tick [16],
	// second_mark [17], refresh_request [18], zero [23:19]
	output logic [lst_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic                      valid_s1;
	logic                      req_s1;
	logic                      pwr_s1;
	logic [lst_pkg::IDX_W-1:0] idx_s1;
	logic [lst_pkg::SEG_W-1:0] data_s1;

	logic                      valid_s2;
	logic [lst_pkg::SEG_W-1:0] seg_s2;
	logic [lst_pkg::COM_W-1:0] com_s2;
	lst_pkg::pulse_t           pulse_s2;

	logic                      advance;
	logic                      tick_en;
	lst_pkg::pulse_t           pulse;
	logic [lst_pkg::SEG_W-1:0] seg_d;
	logic [lst_pkg::COM_W-1:0] com_d;

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign tick_en  = advance & (req_s1 == lst_pkg::REQ_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tuser;
			pwr_s1  <= s_tdata[0];
			idx_s1  <= s_tdata[3:1];
			data_s1 <= s_tdata[11:4];
		end
	end

	lst_timebase #(
		.SUB_TICKS    (SUB_TICKS),
		.SECOND_STEPS (SECOND_STEPS),
		.REFRESH_AT   (REFRESH_AT)
	) u_timebase (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_en (tick_en),
		.pulse   (pulse)
	);

	lst_scan #(
		.DIGITS (DIGITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (pulse.ms_step),
		.power_down  (pwr_s1),
		.write_en    (advance & (req_s1 == lst_pkg::REQ_WRITE)),
		.digit_index (idx_s1),
		.digit_data  (data_s1),
		.seg_d       (seg_d),
		.com_d       (com_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seg_s2   <= seg_d;
			com_s2   <= com_d;
			pulse_s2 <= pulse;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, pulse_s2.refresh_request, pulse_s2.second_mark,
		pulse_s2.sys_tick, pulse_s2.ms_step, com_s2, seg_s2};

`ifndef SYNTH
	a_com_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot0(com_s2))
		else $error("more than one common active");

	a_pulse_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !pulse_s2.ms_step |->
			!(pulse_s2.sys_tick || pulse_s2.second_mark || pulse_s2.refresh_request))
		else $error("pulse without a 1 ms step");

	a_power_down_blank: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en && pwr_s1 && pulse.ms_step |=> (seg_s2 == '0) && (com_s2 == '0))
		else $error("display not blank on power-down step");

	a_write_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_s1 == lst_pkg::REQ_WRITE) |=> !pulse_s2.ms_step)
		else $error("buffer write reported a step");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1) && $stable(data_s1))
		else $error("stalled item lost from input register");
`endif

endmodule

// ===== rtl/lst_timebase.sv =====
// lst_timebase: prescaler and step dividers producing the timing pulses
// depends on lst_pkg

module lst_timebase #(
	parameter int unsigned SUB_TICKS    = lst_pkg::SUB_TICKS_DEF,
	parameter int unsigned SECOND_STEPS = lst_pkg::SECOND_STEPS_DEF,
	parameter int unsigned REFRESH_AT   = lst_pkg::REFRESH_AT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_en,
	output lst_pkg::pulse_t pulse
);

	localparam int unsigned SUB_W = $clog2(SUB_TICKS + 1);
	localparam int unsigned SEC_W = $clog2(SECOND_STEPS + 1);
	localparam int unsigned REF_W = $clog2(REFRESH_AT + 2);

	logic [SUB_W-1:0]               sub_q;
	logic [lst_pkg::SYS_TICK_W-1:0] tick_q;
	logic [SEC_W-1:0]               sec_q;
	logic [REF_W-1:0]               ref_q;

	logic sub_wrap;
	logic tick_wrap;
	logic sec_wrap;
	logic ref_wrap;

	assign sub_wrap  = (sub_q == SUB_W'(SUB_TICKS - 1));
	assign tick_wrap = (tick_q == lst_pkg::SYS_TICK_W'(lst_pkg::SYS_TICK_STEPS - 1));
	assign sec_wrap  = (sec_q == SEC_W'(SECOND_STEPS - 1));
	assign ref_wrap  = (ref_q == REF_W'(REFRESH_AT));

	always_comb begin
		pulse.ms_step         = tick_en & sub_wrap;
		pulse.sys_tick        = tick_en & sub_wrap & tick_wrap;
		pulse.second_mark     = tick_en & sub_wrap & sec_wrap;
		pulse.refresh_request = tick_en & sub_wrap & (ref_q == REF_W'(REFRESH_AT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= '0;
			tick_q <= '0;
			sec_q  <= '0;
			ref_q  <= '0;
		end else if (tick_en) begin
			sub_q <= sub_wrap ? '0 : sub_q + SUB_W'(1);
			if (sub_wrap) begin
				tick_q <= tick_wrap ? '0 : tick_q + lst_pkg::SYS_TICK_W'(1);
				sec_q  <= sec_wrap ? '0 : sec_q + SEC_W'(1);
				ref_q  <= ref_wrap ? '0 : ref_q + REF_W'(1);
			end
		end
	end

endmodule

// ===== rtl/lst_scan.sv =====
// lst_scan: display buffer, scan slot and latched segment/common drive
// depends on lst_pkg

module lst_scan #(
	parameter int unsigned DIGITS = lst_pkg::DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step_en,
	input  logic                      power_down,
	input  logic                      write_en,
	input  logic [lst_pkg::IDX_W-1:0] digit_index,
	input  logic [lst_pkg::SEG_W-1:0] digit_data,
	output logic [lst_pkg::SEG_W-1:0] seg_d,
	output logic [lst_pkg::COM_W-1:0] com_d
);

	localparam int unsigned SLOT_W = $clog2(DIGITS + 1);
	localparam int unsigned BUF_IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [lst_pkg::SEG_W-1:0] buf_q [DIGITS];
	logic [SLOT_W-1:0]         slot_q;
	logic [SLOT_W-1:0]         slot_nxt;
	logic [lst_pkg::SEG_W-1:0] seg_q;
	logic [lst_pkg::COM_W-1:0] com_q;
	logic [lst_pkg::SEG_W-1:0] seg_step;
	logic [lst_pkg::COM_W-1:0] com_step;
	logic [7:0]                com_full;
	logic                      idx_ok;

	assign idx_ok   = (32'(digit_index) < DIGITS);
	assign slot_nxt = (slot_q == SLOT_W'(DIGITS)) ? '0 : slot_q + SLOT_W'(1);
	assign com_full = 8'(1) << slot_nxt;

	always_comb begin
		seg_step = '0;
		com_step = '0;
		if (!power_down && (32'(slot_nxt) < DIGITS)) begin
			seg_step = buf_q[slot_nxt[BUF_IW-1:0]];
			com_step = com_full[lst_pkg::COM_W-1:0];
		end
		seg_d = step_en ? seg_step : seg_q;
		com_d = step_en ? com_step : com_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				buf_q[i] <= '0;
			end
			slot_q <= '0;
			seg_q  <= '0;
			com_q  <= '0;
		end else begin
			if (write_en && idx_ok) begin
				buf_q[digit_index[BUF_IW-1:0]] <= digit_data;
			end
			if (step_en) begin
				seg_q <= seg_step;
				com_q <= com_step;
				if (!power_down) begin
					slot_q <= slot_nxt;
				end
			end
		end
	end

endmodule
